// File: src/trlr_pkg.sv
// Shared widths, register indexes and control types for the tandem repeat run finder.
`timescale 1ns / 1ps

package trlr_pkg;

	localparam int BASE_W    = 2;
	localparam int POS_W     = 16;
	localparam int CNT_W     = 16;
	localparam int PAT_W     = 32;
	localparam int LEN_W     = 5;
	localparam int PIDX_W    = 2;
	localparam int CFG_IDX_W = 3;

	localparam int NUM_CFG_PATTERNS = 4;

	localparam int NUM_PATTERNS_DEF    = 4;
	localparam int MAX_PATTERN_LEN_DEF = 16;
	localparam int SEQ_MAX_DEF         = 65536;

	// Hardware pattern length limit: the pattern registers hold sixteen bases.
	localparam int PAT_BASES = PAT_W / BASE_W;

	localparam logic [CNT_W-1:0] COUNT_MAX = '1;

	// Register index map: patterns first, then lengths.
	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_BASE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LEN_BASE     = 3'd4;

	localparam logic [LEN_W-1:0] LEN_RESET = 5'd1;

	// Control for the update stage of each pattern lane.
	typedef struct packed {
		logic adv;  // pipeline moves this cycle
		logic vld;  // update stage holds a beat
		logic act;  // that beat lies within the sequence limit
		logic eos;  // that beat ends the sequence
	} trlr_ctl_t;

endpackage

// File: src/trlr_if.sv
// Valid/ready channel interfaces for the base stream and the result stream.
`timescale 1ns / 1ps

interface trlr_in_if;
	import trlr_pkg::*;

	logic              valid;
	logic              ready;
	logic [BASE_W-1:0] base;
	logic              end_of_sequence;

	modport source (output valid, output base, output end_of_sequence, input ready);
	modport sink   (input valid, input base, input end_of_sequence, output ready);
endinterface

interface trlr_out_if;
	import trlr_pkg::*;

	logic              valid;
	logic              ready;
	logic [PIDX_W-1:0] pattern_index;
	logic [POS_W-1:0]  run_start;
	logic [CNT_W-1:0]  repeat_count;
	logic              last_result;

	modport source (output valid, output pattern_index, output run_start,
		output repeat_count, output last_result, input ready);
	modport sink   (input valid, input pattern_index, input run_start,
		input repeat_count, input last_result, output ready);
endinterface

// File: src/trlr_lane.sv
// One pattern lane: window compare, per-phase chain counter memory and best-run tracking.
`timescale 1ns / 1ps

module trlr_lane #(
	parameter int LEN_CAP = 16,
	parameter int JW      = 17,
	localparam int PW     = (LEN_CAP > 1) ? $clog2(LEN_CAP) : 1,
	localparam int NW     = $clog2(LEN_CAP + 1)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  trlr_pkg::trlr_ctl_t                 ctl,
	input  logic [trlr_pkg::PAT_W-1:0]          pattern,
	input  logic [trlr_pkg::LEN_W-1:0]          len,
	input  logic [2*LEN_CAP+1:0]                window,
	input  logic [JW:0]                         j_next,
	input  logic [LEN_CAP-1:0][PW-1:0]          res,
	input  logic [trlr_pkg::POS_W-1:0]          j1_s1,
	output logic [trlr_pkg::CNT_W-1:0]          best_cnt,
	output logic [trlr_pkg::POS_W-1:0]          best_start
);
	import trlr_pkg::*;

	logic [CNT_W-1:0] mem [LEN_CAP];

	logic [NW-1:0]    n0;
	logic [PW-1:0]    ph0;
	logic             hit0;

	logic [NW-1:0]    n_s1;
	logic [PW-1:0]    ph_s1;
	logic             hit_s1;
	logic [CNT_W-1:0] rd_q;

	logic [LEN_CAP-1:0] vld_q;
	logic               fwd_v_q;
	logic [PW-1:0]      fwd_a_q;
	logic [CNT_W-1:0]   fwd_d_q;
	logic [CNT_W-1:0]   best_cnt_q;
	logic [POS_W-1:0]   best_start_q;

	logic [CNT_W-1:0]    old_cnt;
	logic [CNT_W-1:0]    inc_cnt;
	logic [CNT_W-1:0]    cnt;
	logic [CNT_W+NW-1:0] prod;
	logic [POS_W-1:0]    start;
	logic                better;
	logic                wr_en;

	// Clamp the configured length into 1..LEN_CAP
	always_comb begin
		if (len == '0) begin
			n0 = NW'(1);
		end else if (len > LEN_W'(LEN_CAP)) begin
			n0 = NW'(LEN_CAP);
		end else begin
			n0 = NW'(len);
		end
	end

	// Pick the phase for this length from the shared residue counters
	assign ph0 = res[PW'(n0 - NW'(1))];

	// Compare the newest n bases against the pattern, oldest base to first pattern base
	always_comb begin
		logic [NW-1:0] idx;
		idx  = '0;
		hit0 = (j_next >= (JW+1)'(n0));
		for (int k = 0; k < LEN_CAP; k++) begin
			if (NW'(k) < n0) begin
				idx = n0 - NW'(1) - NW'(k);
				if (pattern[2*k +: 2] != window[2*idx +: 2]) begin
					hit0 = 1'b0;
				end
			end
		end
	end

	// Read the chain counter and register the compare into the update stage
	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			n_s1   <= n0;
			ph_s1  <= ph0;
			hit_s1 <= hit0;
			rd_q   <= mem[ph0];
		end
	end

	// Write back the updated chain counter
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[ph_s1] <= cnt;
		end
	end

	// Take the write of the previous cycle when it hit the same phase
	always_comb begin
		if (!vld_q[ph_s1]) begin
			old_cnt = '0;
		end else if (fwd_v_q && (fwd_a_q == ph_s1)) begin
			old_cnt = fwd_d_q;
		end else begin
			old_cnt = rd_q;
		end
	end

	// Extend the chain with saturation and test it against the best run
	assign inc_cnt    = (old_cnt == COUNT_MAX) ? old_cnt : CNT_W'(old_cnt + 1'b1);
	assign cnt        = (ctl.act && hit_s1) ? inc_cnt : '0;
	assign prod       = (CNT_W+NW)'(cnt) * (CNT_W+NW)'(n_s1);
	assign start      = j1_s1 - POS_W'(prod);
	assign better     = ctl.act && (cnt > best_cnt_q);
	assign best_cnt   = better ? cnt : best_cnt_q;
	assign best_start = better ? start : best_start_q;
	assign wr_en      = ctl.adv && ctl.vld && ctl.act && !ctl.eos;

	// Hold valid bits, forward register and best run; drop all at sequence end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q        <= '0;
			fwd_v_q      <= 1'b0;
			fwd_a_q      <= '0;
			fwd_d_q      <= '0;
			best_cnt_q   <= '0;
			best_start_q <= '0;
		end else if (ctl.adv) begin
			fwd_v_q <= wr_en;
			fwd_a_q <= ph_s1;
			fwd_d_q <= cnt;
			if (ctl.vld) begin
				if (ctl.eos) begin
					vld_q        <= '0;
					best_cnt_q   <= '0;
					best_start_q <= '0;
				end else begin
					if (ctl.act) begin
						vld_q[ph_s1] <= 1'b1;
					end
					best_cnt_q   <= best_cnt;
					best_start_q <= best_start;
				end
			end
		end
	end

endmodule

// File: src/tandem_repeat_longest_run_top.sv
// The first result beat is offered once the end-of-sequence beat has loaded the result bank.
// Throughput: one base per cycle unless stalled; the results of a sequence leave one per cycle
// from a bank while results.ready is high. The base port stalls only while an end-of-sequence
// beat waits in the update stage for the previous sequence's results to drain.
// Reset clears history, counters, best runs, valid bits and loads the register defaults.
`timescale 1ns / 1ps

module tandem_repeat_longest_run_top #(
	parameter int NUM_PATTERNS    = trlr_pkg::NUM_PATTERNS_DEF,
	parameter int MAX_PATTERN_LEN = trlr_pkg::MAX_PATTERN_LEN_DEF,
	parameter int SEQ_MAX         = trlr_pkg::SEQ_MAX_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [trlr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [trlr_pkg::PAT_W-1:0]     cfg_data,
	trlr_in_if.sink                        bases,
	trlr_out_if.source                     results
);
	import trlr_pkg::*;

	localparam int LEN_CAP = (MAX_PATTERN_LEN < PAT_BASES) ? MAX_PATTERN_LEN : PAT_BASES;
	localparam int PW      = (LEN_CAP > 1) ? $clog2(LEN_CAP) : 1;
	localparam int JW      = $clog2(SEQ_MAX + 1);
	localparam int PIW     = (NUM_PATTERNS > 1) ? $clog2(NUM_PATTERNS) : 1;
	localparam logic [PIW-1:0] LAST_IDX = PIW'(NUM_PATTERNS - 1);

	logic [PAT_W-1:0] pat_q [NUM_CFG_PATTERNS];
	logic [LEN_W-1:0] len_q [NUM_CFG_PATTERNS];

	logic [2*LEN_CAP-1:0]        hist_q;
	logic [JW-1:0]               j_q;
	logic [LEN_CAP-1:0][PW-1:0]  res_q;

	logic                 s1_vld_q;
	logic                 s1_act;
	logic                 s1_eos;
	logic [POS_W-1:0]     s1_j1;

	logic [CNT_W-1:0] bank_cnt_q   [NUM_PATTERNS];
	logic [POS_W-1:0] bank_start_q [NUM_PATTERNS];
	logic             busy_q;
	logic [PIW-1:0]   idx_q;

	logic [NUM_PATTERNS-1:0][CNT_W-1:0] lane_cnt;
	logic [NUM_PATTERNS-1:0][POS_W-1:0] lane_start;

	logic                 acc;
	logic                 adv;
	logic                 stall;
	logic                 out_acc;
	logic                 drain_done;
	logic                 act0;
	logic [2*LEN_CAP+1:0] window;
	logic [JW:0]          j_next;
	trlr_ctl_t            ctl;

	// Store configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < NUM_CFG_PATTERNS; p++) begin
				pat_q[p] <= '0;
				len_q[p] <= LEN_RESET;
			end
		end else if (cfg_we) begin
			if (cfg_index < CFG_LEN_BASE) begin
				pat_q[cfg_index[1:0]] <= cfg_data;
			end else begin
				len_q[cfg_index[1:0]] <= cfg_data[LEN_W-1:0];
			end
		end
	end

	// Handshake and stall: an end beat waits until the result bank frees
	assign out_acc    = results.valid && results.ready;
	assign drain_done = out_acc && (idx_q == LAST_IDX);
	assign stall      = s1_vld_q && s1_eos && busy_q && !drain_done;
	assign adv        = !stall;
	assign acc        = bases.valid && bases.ready;
	assign bases.ready = adv;

	assign act0   = (j_q < JW'(SEQ_MAX));
	assign window = {hist_q, bases.base};
	assign j_next = {1'b0, j_q} + 1'b1;

	// Advance history, position and residues per accepted base within the sequence limit; clear at sequence end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q <= '0;
			j_q    <= '0;
			res_q  <= '0;
		end else if (acc) begin
			if (bases.end_of_sequence) begin
				hist_q <= '0;
				j_q    <= '0;
				res_q  <= '0;
			end else if (act0) begin
				hist_q <= window[2*LEN_CAP-1:0];
				j_q    <= JW'(j_next);
				for (int k = 0; k < LEN_CAP; k++) begin
					res_q[k] <= (res_q[k] == PW'(k)) ? '0 : PW'(res_q[k] + 1'b1);
				end
			end
		end
	end

	// Update stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q <= 1'b0;
		end else if (adv) begin
			s1_vld_q <= acc;
		end
	end

	// Update stage payload
	always_ff @(posedge clk) begin
		if (adv) begin
			s1_act <= act0;
			s1_eos <= bases.end_of_sequence;
			s1_j1  <= POS_W'(j_next);
		end
	end

	assign ctl = '{adv: adv, vld: s1_vld_q, act: s1_act, eos: s1_eos};

	// One lane per pattern
	for (genvar p = 0; p < NUM_PATTERNS; p++) begin : g_lane
		trlr_lane #(
			.LEN_CAP (LEN_CAP),
			.JW      (JW)
		) u_lane (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.pattern    (pat_q[p]),
			.len        (len_q[p]),
			.window     (window),
			.j_next     (j_next),
			.res        (res_q),
			.j1_s1      (s1_j1),
			.best_cnt   (lane_cnt[p]),
			.best_start (lane_start[p])
		);
	end

	// Load the result bank at sequence end; drain one beat per cycle while results.ready is high
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (adv && s1_vld_q && s1_eos) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (out_acc) begin
			if (idx_q == LAST_IDX) begin
				busy_q <= 1'b0;
			end
			idx_q <= PIW'(idx_q + 1'b1);
		end
	end

	always_ff @(posedge clk) begin
		if (adv && s1_vld_q && s1_eos) begin
			for (int p = 0; p < NUM_PATTERNS; p++) begin
				bank_cnt_q[p]   <= lane_cnt[p];
				bank_start_q[p] <= lane_start[p];
			end
		end
	end

	// Present the current result beat
	assign results.valid         = busy_q;
	assign results.pattern_index = PIDX_W'(idx_q);
	assign results.run_start     = bank_start_q[idx_q];
	assign results.repeat_count  = bank_cnt_q[idx_q];
	assign results.last_result   = (idx_q == LAST_IDX);

endmodule

// File: tb/trlr_checker.sv
// Scoreboard for the tandem repeat run finder: predicts and checks the result beats.
`timescale 1ns / 1ps

module trlr_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [trlr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [trlr_pkg::PAT_W-1:0]     cfg_data,
	trlr_in_if                             bases_mon,
	trlr_out_if                            results_mon,
	output int                             fail_count,
	output int                             pending
);
	import trlr_pkg::*;

	localparam int NUM_PAT   = NUM_PATTERNS_DEF;
	localparam int LEN_CAP   = (MAX_PATTERN_LEN_DEF < PAT_BASES) ? MAX_PATTERN_LEN_DEF : PAT_BASES;
	localparam int SEQ_LIMIT = SEQ_MAX_DEF;

	typedef struct packed {
		logic [PIDX_W-1:0] pattern_index;
		logic [POS_W-1:0]  run_start;
		logic [CNT_W-1:0]  repeat_count;
		logic              last_result;
	} run_report_t;

	// Register copies
	logic [PAT_W-1:0] pat_bases [NUM_CFG_PATTERNS];
	logic [LEN_W-1:0] pat_len   [NUM_CFG_PATTERNS];

	// Sequence state
	logic [PAT_W-1:0] history;
	logic [CNT_W-1:0] chain      [NUM_CFG_PATTERNS][PAT_BASES];
	logic [CNT_W-1:0] best_count [NUM_CFG_PATTERNS];
	logic [POS_W-1:0] best_start [NUM_CFG_PATTERNS];
	int unsigned      seq_pos;

	run_report_t expected_runs[$];
	run_report_t want;

	function automatic void clear_sequence();
		history = '0;
		seq_pos = 0;
		for (int p = 0; p < NUM_CFG_PATTERNS; p++) begin
			best_count[p] = '0;
			best_start[p] = '0;
			for (int k = 0; k < PAT_BASES; k++)
				chain[p][k] = '0;
		end
	endfunction

	// Effective pattern length: zero counts as one, oversize clamps to the cap.
	function automatic int unsigned span_of(int p);
		int unsigned n;
		n = pat_len[p];
		if (n == 0)
			n = 1;
		if (n > LEN_CAP)
			n = LEN_CAP;
		return n;
	endfunction

	// True when the newest n bases spell pattern p.
	function automatic bit copy_ends_here(int p, int unsigned n);
		for (int k = 0; k < n; k++)
			if (pat_bases[p][2*k +: 2] != history[2*(n-1-k) +: 2])
				return 1'b0;
		return 1'b1;
	endfunction

	// Advance the run tracking by one base; on end of sequence queue one report per pattern.
	function automatic void track_base(logic [BASE_W-1:0] b, logic eos);
		int unsigned n;
		int unsigned phase;
		int unsigned c;
		int unsigned j;
		run_report_t r;
		if (seq_pos < SEQ_LIMIT) begin
			j = seq_pos;
			history = {history[PAT_W-BASE_W-1:0], b};
			for (int p = 0; p < NUM_PAT; p++) begin
				n = span_of(p);
				phase = j % n;
				c = 0;
				if (j + 1 >= n && copy_ends_here(p, n)) begin
					c = chain[p][phase];
					if (c < COUNT_MAX)
						c++;
				end
				chain[p][phase] = CNT_W'(c);
				if (c > best_count[p]) begin
					best_count[p] = CNT_W'(c);
					best_start[p] = POS_W'(j + 1 - c * n);
				end
			end
			seq_pos = j + 1;
		end
		if (eos) begin
			for (int p = 0; p < NUM_PAT; p++) begin
				r.pattern_index = PIDX_W'(p);
				r.run_start     = best_start[p];
				r.repeat_count  = best_count[p];
				r.last_result   = (p == NUM_PAT - 1);
				expected_runs.insert(expected_runs.size(), r);
			end
			clear_sequence();
		end
	endfunction

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $time, what);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < NUM_CFG_PATTERNS; p++) begin
				pat_bases[p] = '0;
				pat_len[p]   = LEN_RESET;
			end
			clear_sequence();
			expected_runs.delete();
			fail_count = 0;
			pending <= 0;
		end else begin
			// Check result beats against the oldest report first
			if (results_mon.valid && results_mon.ready) begin
				if (expected_runs.size() == 0) begin
					report_mismatch($sformatf("unexpected result beat, pattern %0d",
						results_mon.pattern_index));
				end else begin
					want = expected_runs.pop_front();
					if (results_mon.pattern_index !== want.pattern_index)
						report_mismatch($sformatf("pattern_index got %0d want %0d",
							results_mon.pattern_index, want.pattern_index));
					if (results_mon.run_start !== want.run_start)
						report_mismatch($sformatf("pattern %0d run_start got %0d want %0d",
							want.pattern_index, results_mon.run_start, want.run_start));
					if (results_mon.repeat_count !== want.repeat_count)
						report_mismatch($sformatf("pattern %0d repeat_count got %0d want %0d",
							want.pattern_index, results_mon.repeat_count, want.repeat_count));
					if (results_mon.last_result !== want.last_result)
						report_mismatch($sformatf("pattern %0d last_result got %0b want %0b",
							want.pattern_index, results_mon.last_result, want.last_result));
				end
			end

			// Track register writes
			if (cfg_we) begin
				if (cfg_index < CFG_LEN_BASE)
					pat_bases[int'(cfg_index) - int'(CFG_PATTERN_BASE)] = cfg_data;
				else
					pat_len[int'(cfg_index) - int'(CFG_LEN_BASE)] = cfg_data[LEN_W-1:0];
			end

			// Predict from accepted base beats
			if (bases_mon.valid && bases_mon.ready)
				track_base(bases_mon.base, bases_mon.end_of_sequence);

			pending <= expected_runs.size();
		end
	end

endmodule

// File: tb/tb_top.sv
// Testbench top for the tandem repeat run finder: clock, reset, setup, stimulus, verdict.
`timescale 1ns / 1ps

module tb_top;
	import trlr_pkg::*;

	localparam int HALF_PERIOD    = 5;
	localparam int RESET_CYCLES   = 12;
	localparam int SETTLE_CYCLES  = 8;
	localparam int MAX_IDLE       = 18;
	localparam int PHASE_BASES    = 75;
	localparam int TIMEOUT_CYCLES = 1000000;

	localparam logic [BASE_W-1:0] BASE_A = 2'd0;
	localparam logic [BASE_W-1:0] BASE_C = 2'd1;
	localparam logic [BASE_W-1:0] BASE_G = 2'd2;
	localparam logic [BASE_W-1:0] BASE_T = 2'd3;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [PAT_W-1:0]     cfg_data;

	trlr_in_if  bases_ch ();
	trlr_out_if results_ch ();

	int fail_count;
	int pending;
	bit no_idle;

	// Register settings for the stimulus side
	logic [PAT_W-1:0] set_pat [NUM_CFG_PATTERNS];
	logic [LEN_W-1:0] set_len [NUM_CFG_PATTERNS];

	logic [BASE_W-1:0] strand[$];

	tandem_repeat_longest_run_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.bases     (bases_ch),
		.results   (results_ch)
	);

	trlr_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.bases_mon   (bases_ch),
		.results_mon (results_ch),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	initial begin
		clk = 1'b0;
		forever #HALF_PERIOD clk = ~clk;
	end

	initial begin
		repeat (TIMEOUT_CYCLES) @(posedge clk);
		$display("tandem_repeat_longest_run_top test failed");
		$finish;
	end

	// Result sink: stall a random number of cycles before each beat
	initial begin
		int stall;
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
			if (stall > 0) begin
				results_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			results_ch.ready <= 1'b1;
			do @(posedge clk); while (!results_ch.valid);
		end
	end

	function automatic logic [BASE_W-1:0] code_of(byte ch);
		case (ch)
			"C": return BASE_C;
			"G": return BASE_G;
			"T": return BASE_T;
			default: return BASE_A;
		endcase
	endfunction

	function automatic logic [PAT_W-1:0] pack_pattern(string s);
		logic [PAT_W-1:0] r;
		r = '0;
		for (int i = 0; i < s.len(); i++)
			r[2*i +: 2] = code_of(s[i]);
		return r;
	endfunction

	// Append one base to the staged sequence
	function automatic void add_base(logic [BASE_W-1:0] b);
		strand.insert(strand.size(), b);
	endfunction

	function automatic void stage(string s);
		for (int i = 0; i < s.len(); i++)
			add_base(code_of(s[i]));
	endfunction

	function automatic int span_of(int p);
		int n;
		n = set_len[p];
		if (n == 0)
			n = 1;
		if (n > PAT_BASES)
			n = PAT_BASES;
		return n;
	endfunction

	// Offer one base after a random gap and hold it until taken; valid stays high afterwards.
	task automatic send_base(input logic [BASE_W-1:0] b, input logic last);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
		if (gap > 0) begin
			bases_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		bases_ch.valid           <= 1'b1;
		bases_ch.base            <= b;
		bases_ch.end_of_sequence <= last;
		do @(posedge clk); while (!bases_ch.ready);
	endtask

	task automatic send_strand(input bit close);
		for (int i = 0; i < strand.size(); i++)
			send_base(strand[i], close && (i == strand.size() - 1));
		strand.delete();
	endtask

	// Drop valid, wait for every report to arrive, then let the pipeline empty.
	task automatic drain();
		bases_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write all eight registers back to back; length writes carry junk in the upper bits.
	task automatic load_config();
		for (int i = 0; i < NUM_CFG_PATTERNS; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= CFG_PATTERN_BASE + CFG_IDX_W'(i);
			cfg_data  <= set_pat[i];
			@(posedge clk);
		end
		for (int i = 0; i < NUM_CFG_PATTERNS; i++) begin
			cfg_index <= CFG_LEN_BASE + CFG_IDX_W'(i);
			cfg_data  <= ($urandom() & ~PAT_W'(5'h1f)) | PAT_W'(set_len[i]);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic pick_config(input int kind);
		for (int p = 0; p < NUM_CFG_PATTERNS; p++) begin
			set_pat[p] = $urandom();
			case (kind)
				0: set_len[p] = LEN_W'($urandom_range(1, 4));
				1: begin
					case ($urandom_range(0, 3))
						0: set_len[p] = 5'd0;
						1: set_len[p] = 5'd1;
						2: set_len[p] = 5'd2;
						default: set_len[p] = 5'd16;
					endcase
				end
				2: set_len[p] = LEN_W'($urandom_range(1, 16));
				default: set_len[p] = LEN_W'($urandom_range(0, 31));
			endcase
		end
	endtask

	// Build one sequence of tandem runs of the configured patterns, broken copies and noise.
	task automatic build_strand();
		int p;
		int n;
		int copies;
		int idx;
		repeat ($urandom_range(1, 6)) begin
			if ($urandom_range(0, 9) < 2) begin
				repeat ($urandom_range(1, 4))
					add_base(BASE_W'($urandom_range(0, 3)));
			end else begin
				p = $urandom_range(0, NUM_CFG_PATTERNS - 1);
				n = span_of(p);
				copies = (n > 4) ? $urandom_range(1, 3) : $urandom_range(1, 6);
				repeat (copies)
					for (int k = 0; k < n; k++)
						add_base(set_pat[p][2*k +: 2]);
				// Break the last copy now and then
				if ($urandom_range(0, 4) == 0) begin
					idx = strand.size() - 1 - $urandom_range(0, n - 1);
					strand[idx] = strand[idx] ^ BASE_W'($urandom_range(1, 3));
				end
			end
		end
	endtask

	task automatic random_phase(input int quota);
		int sent;
		sent = 0;
		while (sent < quota) begin
			no_idle = ($urandom_range(0, 3) == 0);
			build_strand();
			sent += strand.size();
			send_strand(1'b1);
		end
	endtask

	initial begin
		arst_n                   <= 1'b0;
		cfg_we                   <= 1'b0;
		cfg_index                <= '0;
		cfg_data                 <= '0;
		bases_ch.valid           <= 1'b0;
		bases_ch.base            <= '0;
		bases_ch.end_of_sequence <= 1'b0;
		no_idle = 1'b0;
		for (int p = 0; p < NUM_CFG_PATTERNS; p++) begin
			set_pat[p] = '0;
			set_len[p] = LEN_RESET;
		end
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		repeat (SETTLE_CYCLES) @(posedge clk);

		// Reset defaults: every pattern is a single A
		stage("AACA");
		send_strand(1'b1);
		drain();

		// Zero length, oversize lengths, all-T pattern
		set_pat[0] = pack_pattern("A");
		set_len[0] = 5'd0;
		set_pat[1] = pack_pattern("AC");
		set_len[1] = 5'd2;
		set_pat[2] = '1;
		set_len[2] = 5'd31;
		set_pat[3] = pack_pattern("GT");
		set_len[3] = 5'd17;
		load_config();

		// Sequence of one base, shorter than every pattern but pattern 0
		stage("T");
		send_strand(1'b1);
		// Two equal runs: the earlier one stands
		stage("ACACGACAC");
		send_strand(1'b1);

		// Change a pattern in the middle of a sequence
		stage("AAA");
		send_strand(1'b0);
		drain();
		set_pat[1] = pack_pattern("ACG");
		set_len[1] = 5'd3;
		load_config();
		stage("ACGACG");
		send_strand(1'b1);
		drain();

		// Random sequences under several settings
		for (int kind = 0; kind < 4; kind++) begin
			pick_config(kind);
			load_config();
			random_phase(PHASE_BASES);
			drain();
		end

		if (fail_count == 0 && pending == 0)
			$display("tandem_repeat_longest_run_top test passed");
		else
			$display("tandem_repeat_longest_run_top test failed");
		$finish;
	end

endmodule

// File: filelist.f
src/trlr_pkg.sv
src/trlr_if.sv
src/trlr_lane.sv
src/tandem_repeat_longest_run_top.sv
tb/trlr_checker.sv
tb/tb_top.sv
